[rtl/core/masked_rank_window_filter_assert.svh]
// Assertion macros used by the port checker file.
`ifndef MASKED_RANK_WINDOW_FILTER_ASSERT_SVH
`define MASKED_RANK_WINDOW_FILTER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MRWF_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MRWF_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);
`endif

[rtl/core/mrwf_pkg.sv]
// Package: shared constants and types of the masked rank filter.
`timescale 1ns / 1ps
package mrwf_pkg;
   localparam int MaxWindow = 5;
   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;
   localparam int WinTaps   = MaxWindow * MaxWindow;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = $clog2(MaxHeight);
   localparam int LineSelW  = $clog2(MaxWindow);
   localparam int TapIdxW   = $clog2(WinTaps + 1);

   localparam logic [2:0] CsrImageWidth  = 3'd0;
   localparam logic [2:0] CsrImageHeight = 3'd1;
   localparam logic [2:0] CsrWindowRows  = 3'd2;
   localparam logic [2:0] CsrWindowCols  = 3'd3;
   localparam logic [2:0] CsrApertureMask = 3'd4;
   localparam logic [2:0] CsrRankSelect  = 3'd5;

   typedef logic [7:0] pixel_type;

   typedef struct packed {
      logic [7:0] value;
      logic       mask;
   } tap_type;

   typedef struct packed {
      logic       last_col;
      logic       last_frame;
      logic [4:0] rank;
   } tag_type;
endpackage

[rtl/core/mrwf_rank_cell.sv]
// Rank cell: holds one sorted slot and passes its displaced value to the next.
`timescale 1ns / 1ps
module mrwf_rank_cell import mrwf_pkg::*; (
   input  logic      clock,
   input  logic      clear,
   input  logic      ins_valid,
   input  pixel_type ins_value,
   input  logic      prev_full,
   input  pixel_type prev_value,
   input  logic      prev_takes,
   output logic      full,
   output pixel_type value,
   output logic      takes
);
   logic      full_ff, full_in;
   pixel_type value_ff, value_in;

   // A cell takes the new value when it holds a larger one, or when it is the first empty one.
   assign takes = ins_valid && (full_ff ? (value_ff > ins_value) : prev_full);

   always_comb begin
      full_in  = full_ff;
      value_in = value_ff;
      if (clear) begin
         full_in = 1'b0;
      end else if (takes) begin
         full_in  = 1'b1;
         value_in = prev_takes ? prev_value : ins_value;
      end
   end

   always_ff @(posedge clock) begin
      full_ff  <= full_in;
      value_ff <= value_in;
   end

   assign full  = full_ff;
   assign value = value_ff;
endmodule

[rtl/core/mrwf_rank_chain.sv]
// Rank chain: row of insertion cells that sorts the masked taps one per cycle.
`timescale 1ns / 1ps
module mrwf_rank_chain import mrwf_pkg::*; (
   input  logic      clock,
   input  logic      clear,
   input  logic      ins_valid,
   input  pixel_type ins_value,
   input  logic [4:0] rank,
   output logic      hit,
   output pixel_type pick
);
   logic      full_w  [WinTaps];
   pixel_type value_w [WinTaps];
   logic      takes_w [WinTaps];

   for (genvar g = 0; g < WinTaps; g++) begin : g_cell
      logic      pf;
      pixel_type pv;
      logic      pt;
      if (g == 0) begin : g_first
         assign pf = 1'b1;
         assign pv = '0;
         assign pt = 1'b0;
      end else begin : g_rest
         assign pf = full_w[g-1];
         assign pv = value_w[g-1];
         assign pt = takes_w[g-1];
      end
      mrwf_rank_cell u_cell (
         .clock(clock), .clear(clear), .ins_valid(ins_valid), .ins_value(ins_value),
         .prev_full(pf), .prev_value(pv), .prev_takes(pt),
         .full(full_w[g]), .value(value_w[g]), .takes(takes_w[g])
      );
   end

   always_comb begin
      hit  = 1'b0;
      pick = '0;
      for (int c = 0; c < WinTaps; c++) begin
         if (rank == 5'(c + 1) && full_w[c]) begin
            hit  = 1'b1;
            pick = value_w[c];
         end
      end
   end
endmodule

[rtl/core/masked_rank_window_filter.sv]
// Top level: masked rank-order window filter on a raster pixel stream.
// Pixels enter on req_ (tdata = pixel_in, tuser = frame_start) one per transfer.
// Each pixel is written to a ring of five line memories. When it completes a
// window inside the valid crop, the window taps are read from the line memories
// one tap per cycle and pushed into a chain of 25 insertion cells that keeps
// masked taps in ascending order. The chosen rank is read from the chain and
// placed in the output register.
// rsp_ carries tdata = filtered_value, tlast = row_end, tuser bit 0 = frame_end
// and tuser bit 1 = rank_error. An item that yields no result leaves the block in
// its idle state, so such pixels may follow back to back. For one that yields a
// result, the block reads the taps through the single read port of the line
// memories, waits in a done state for the last tap to enter the chain, and then
// makes rsp_ valid from the output register. The output register holds a result
// while rsp_tready is low; no new pixel is taken until it drains.
// Reset (synchronous, active high) restores the default configuration and clears
// the position counters; line memory contents are left undefined. csr_ writes
// take effect at once and must be made only while the block is idle (unchecked).
`timescale 1ns / 1ps
module masked_rank_window_filter import mrwf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] pixel_in
   input  logic        req_tuser,  // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] filtered_value
   output logic        rsp_tlast,  // row_end
   output logic [1:0]  rsp_tuser,  // [0] frame_end, [1] rank_error
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   typedef enum logic [3:0] {
      StIdle = 4'b0001, StRead = 4'b0010, StDone = 4'b0100, StOut = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [10:0] width_ff, height_ff;
   logic [2:0]  wrows_ff, wcols_ff;
   logic [24:0] mask_ff;
   logic [4:0]  rank_ff;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [LineSelW-1:0] wline_ff, wline_in;
   logic [LineSelW-1:0] y_line;

   pixel_type mem [MaxWindow][MaxWidth];
   pixel_type rd_ff;
   logic      rd_valid_ff, rd_mask_ff;

   // clamped configuration
   logic [10:0] w_c, h_c;
   logic [2:0]  wr_c, wc_c;
   always_comb begin
      w_c  = (width_ff == 0) ? 11'd1 : (width_ff > 11'(MaxWidth)) ? 11'(MaxWidth) : width_ff;
      h_c  = (height_ff == 0) ? 11'd1 :
             (height_ff > 11'(MaxHeight)) ? 11'(MaxHeight) : height_ff;
      wr_c = (wrows_ff == 0) ? 3'd1 : (wrows_ff > 3'(MaxWindow)) ? 3'(MaxWindow) : wrows_ff;
      wc_c = (wcols_ff == 0) ? 3'd1 : (wcols_ff > 3'(MaxWindow)) ? 3'(MaxWindow) : wcols_ff;
   end

   logic [10:0] ow, oh;
   always_comb begin
      ow = (w_c > 11'({wc_c[2:1], 1'b0})) ? w_c - 11'({wc_c[2:1], 1'b0}) : 11'd0;
      oh = (h_c > 11'({wr_c[2:1], 1'b0})) ? h_c - 11'({wr_c[2:1], 1'b0}) : 11'd0;
   end

   logic            accept;
   logic [ColW-1:0] x;
   logic [RowW-1:0] y;
   logic [10:0]     j, i;
   logic            emit;
   assign req_tready = (state_ff == StIdle);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      x = req_tuser ? '0 : ((11'(col_ff) >= w_c) ? '0 : col_ff);
      y = req_tuser ? '0 : ((11'(row_ff) >= h_c) ? '0 : row_ff);
      y_line = (req_tuser || (11'(row_ff) >= h_c)) ? '0 : wline_ff;
      j = 11'(x) + 11'd1 - 11'(wc_c);
      i = 11'(y) + 11'd1 - 11'(wr_c);
      emit = (11'(x) + 11'd1 >= 11'(wc_c)) && (11'(y) + 11'd1 >= 11'(wr_c))
             && (j < ow) && (i < oh);
      col_in = col_ff;
      row_in = row_ff;
      wline_in = wline_ff;
      if (accept) begin
         if (11'(x) + 11'd1 >= w_c) begin
            col_in = '0;
            if (11'(y) + 11'd1 >= h_c) begin
               row_in   = '0;
               wline_in = '0;
            end else begin
               row_in   = y + 1'b1;
               wline_in = (y_line == LineSelW'(MaxWindow - 1)) ? '0 : y_line + 1'b1;
            end
         end else begin
            col_in   = x + 1'b1;
            row_in   = y;
            wline_in = y_line;
         end
      end
   end

   // window scan position
   logic [10:0]     j_ff;
   logic [2:0]      k_ff, l_ff;
   logic [2:0]      k_in, l_in;
   logic [LineSelW-1:0] line_ff, line_in;
   logic            last_col_ff, last_frame_ff;
   logic            scan_last;
   logic [4:0]      bit_idx;

   assign scan_last = (k_ff == wr_c - 3'd1) && (l_ff == wc_c - 3'd1);
   assign bit_idx   = 5'(k_ff) * 5'(wc_c) + 5'(l_ff);

   always_comb begin
      k_in = k_ff;
      l_in = l_ff;
      line_in = line_ff;
      if (state_ff == StRead) begin
         if (l_ff == wc_c - 3'd1) begin
            l_in = '0;
            k_in = k_ff + 3'd1;
            line_in = (line_ff == LineSelW'(MaxWindow - 1)) ? '0 : line_ff + 1'b1;
         end else begin
            l_in = l_ff + 3'd1;
         end
      end
   end

   // top window row in the line ring: (y + 1 - rows) mod 5
   logic [LineSelW-1:0] line_start;
   logic [3:0]          line_sum;
   always_comb begin
      line_sum   = 4'(y_line) + 4'd6 - 4'(wr_c);
      line_start = (line_sum >= 4'd5) ? LineSelW'(line_sum - 4'd5) : LineSelW'(line_sum);
   end

   logic      hit;
   pixel_type pick;
   logic      chain_clear;
   logic [4:0] mask_bit_ok;
   assign chain_clear = accept;
   assign mask_bit_ok = bit_idx;

   mrwf_rank_chain u_chain (
      .clock(clock), .clear(chain_clear), .ins_valid(rd_valid_ff && rd_mask_ff),
      .ins_value(rd_ff), .rank(rank_ff), .hit(hit), .pick(pick)
   );

   logic [7:0] out_data_ff;
   logic       out_err_ff, out_row_ff, out_frame_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: if (accept && emit) state_in = StRead;
         StRead: if (scan_last) state_in = StDone;
         StDone: if (!rd_valid_ff) state_in = StOut;
         StOut:  if (rsp_tready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) mem[y_line][x] <= req_tdata;
      if (state_ff == StRead) rd_ff <= mem[line_ff][10'(j_ff) + 10'(l_ff)];
      rd_mask_ff <= (state_ff == StRead) && (mask_bit_ok < 5'd25) && mask_ff[mask_bit_ok];
      if (accept) begin
         j_ff <= j;
         last_col_ff   <= (j + 11'd1 == ow);
         last_frame_ff <= (j + 11'd1 == ow) && (i + 11'd1 == oh);
      end
      if (state_ff == StDone && !rd_valid_ff) begin
         out_data_ff  <= (rank_ff != 0 && hit) ? pick : 8'd0;
         out_err_ff   <= !(rank_ff != 0 && hit);
         out_row_ff   <= last_col_ff;
         out_frame_ff <= last_frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StIdle;
         col_ff      <= '0;
         row_ff      <= '0;
         wline_ff    <= '0;
         k_ff        <= '0;
         l_ff        <= '0;
         line_ff     <= '0;
         rd_valid_ff <= 1'b0;
         width_ff    <= 11'd640;
         height_ff   <= 11'd480;
         wrows_ff    <= 3'd3;
         wcols_ff    <= 3'd3;
         mask_ff     <= 25'd511;
         rank_ff     <= 5'd5;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         wline_ff    <= wline_in;
         rd_valid_ff <= (state_ff == StRead);
         if (accept) begin
            k_ff    <= '0;
            l_ff    <= '0;
            line_ff <= line_start;
         end else begin
            k_ff    <= k_in;
            l_ff    <= l_in;
            line_ff <= line_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CsrImageWidth:   width_ff  <= csr_wdata[10:0];
               CsrImageHeight:  height_ff <= csr_wdata[10:0];
               CsrWindowRows:   wrows_ff  <= csr_wdata[2:0];
               CsrWindowCols:   wcols_ff  <= csr_wdata[2:0];
               CsrApertureMask: mask_ff   <= csr_wdata;
               CsrRankSelect:   rank_ff   <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = (state_ff == StOut);
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_row_ff;
   assign rsp_tuser  = {out_err_ff, out_frame_ff};
endmodule

[rtl/core/mrwf_port_checker.sv]
// Port checker for the masked rank filter, bound to the top level.
`timescale 1ns / 1ps
`include "masked_rank_window_filter_assert.svh"
module mrwf_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);
   `MRWF_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser[1],
      rsp_tdata == 8'd0, "error result not zero")
   `MRWF_ASSERT_IMPLY(a_frame_row, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tlast, "frame end without row end")
   `MRWF_ASSERT_IMPLY(a_no_take_busy, clock, reset, rsp_tvalid,
      !req_tready, "input taken while result waits")
   `MRWF_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
endmodule

bind masked_rank_window_filter mrwf_port_checker u_mrwf_port_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
);

[dv/masked_rank_window_filter_tb.sv]
// Testbench for the masked rank window filter: stream of frames, self-predicting scoreboard.
`timescale 1ns / 1ps
module masked_rank_window_filter_tb;
   import mrwf_pkg::*;

   typedef struct {
      logic [7:0] filtered_value;
      logic       row_end;
      logic       frame_end;
      logic       rank_error;
   } filter_out_t;

   class rank_filter_scoreboard;
      int unsigned img_w = 640, img_h = 480, win_r = 3, win_c = 3, rank = 5;
      logic [24:0] aperture = 25'd511;
      logic [7:0]  line_mem [MaxWindow][MaxWidth];
      int unsigned col = 0, row = 0;
      filter_out_t expected_outputs[$];
      int          failures = 0;

      function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function void set_reg(logic [2:0] idx, logic [24:0] val);
         case (idx)
            CsrImageWidth:   img_w = 32'(val[10:0]);
            CsrImageHeight:  img_h = 32'(val[10:0]);
            CsrWindowRows:   win_r = 32'(val[2:0]);
            CsrWindowCols:   win_c = 32'(val[2:0]);
            CsrApertureMask: aperture = val;
            CsrRankSelect:   rank = 32'(val[4:0]);
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [7:0] px, logic fs);
         int unsigned w, h, wr, wc, x, y, ow, oh, j, i, n, b, m;
         logic [7:0] vals[25];
         logic [7:0] v;
         filter_out_t r;
         w = clamp(img_w, 1, MaxWidth);
         h = clamp(img_h, 1, MaxHeight);
         wr = clamp(win_r, 1, MaxWindow);
         wc = clamp(win_c, 1, MaxWindow);
         if (fs) begin
            col = 0;
            row = 0;
         end
         if (col >= w) col = 0;
         if (row >= h) row = 0;
         x = col;
         y = row;
         line_mem[y % MaxWindow][x] = px;
         ow = 2 * (wc / 2);
         oh = 2 * (wr / 2);
         ow = (w > ow) ? w - ow : 0;
         oh = (h > oh) ? h - oh : 0;
         if (x + 1 >= wc && y + 1 >= wr) begin
            j = x + 1 - wc;
            i = y + 1 - wr;
            if (j < ow && i < oh) begin
               n = 0;
               for (int k = 0; k < wr; k++) begin
                  for (int l = 0; l < wc; l++) begin
                     b = k * wc + l;
                     if (b < 25 && aperture[b]) begin
                        v = line_mem[(i + k) % MaxWindow][j + l];
                        m = n;
                        while (m > 0 && vals[m - 1] > v) begin
                           vals[m] = vals[m - 1];
                           m--;
                        end
                        vals[m] = v;
                        n++;
                     end
                  end
               end
               if (rank == 0 || rank > n) begin
                  r.filtered_value = 8'd0;
                  r.rank_error = 1'b1;
               end else begin
                  r.filtered_value = vals[rank - 1];
                  r.rank_error = 1'b0;
               end
               r.row_end = (j + 1 == ow);
               r.frame_end = (j + 1 == ow) && (i + 1 == oh);
               expected_outputs.insert(expected_outputs.size(), r);
            end
         end
         col = x + 1;
         if (col >= w) begin
            col = 0;
            row = y + 1;
            if (row >= h) row = 0;
         end
      endfunction

      function void check_output(filter_out_t act);
         filter_out_t e;
         if (expected_outputs.size() == 0) begin
            $error("unexpected output transfer, value %0d", act.filtered_value);
            failures++;
            return;
         end
         e = expected_outputs.pop_front();
         if (act.filtered_value !== e.filtered_value) begin
            $error("filtered_value expected %0d actual %0d", e.filtered_value,
                   act.filtered_value);
            failures++;
         end
         if (act.row_end !== e.row_end) begin
            $error("row_end expected %0d actual %0d", e.row_end, act.row_end);
            failures++;
         end
         if (act.frame_end !== e.frame_end) begin
            $error("frame_end expected %0d actual %0d", e.frame_end, act.frame_end);
            failures++;
         end
         if (act.rank_error !== e.rank_error) begin
            $error("rank_error expected %0d actual %0d", e.rank_error, act.rank_error);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;  // [7:0] pixel_in
   logic        req_tuser = 1'b0;  // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] filtered_value
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;         // [0] frame_end, [1] rank_error
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [24:0] csr_wdata = 25'd0;

   rank_filter_scoreboard sb = new();
   int unsigned send_idle = 0, recv_idle = 0, pixels_sent = 0, stall_cycles = 0;
   bit need_frame_start = 1'b1;

   masked_rank_window_filter dut (.*);

   always #5 clock = ~clock;

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      filter_out_t act;
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            act.filtered_value = rsp_tdata;
            act.row_end = rsp_tlast;
            act.frame_end = rsp_tuser[0];
            act.rank_error = rsp_tuser[1];
            sb.check_output(act);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles == 5000) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [24:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned wr, int unsigned wc,
                            logic [24:0] msk, int unsigned rk);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (sb.expected_outputs.size() == 0);
      repeat (40) @(posedge clock);
      write_reg(CsrImageWidth, 25'(w));
      write_reg(CsrImageHeight, 25'(h));
      write_reg(CsrWindowRows, 25'(wr));
      write_reg(CsrWindowCols, 25'(wc));
      write_reg(CsrApertureMask, msk);
      write_reg(CsrRankSelect, 25'(rk));
      @(negedge clock);
      csr_we <= 1'b0;
      need_frame_start = 1'b1;
   endtask

   task automatic send_pixel(logic [7:0] px, logic fs);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      req_tuser <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2, 3: return 8'($urandom_range(3) * 85);
         default: return 8'($urandom);
      endcase
   endfunction

   // noise: restart markers mid-frame, truncated frames
   task automatic send_frame(bit noisy);
      int unsigned w, h;
      logic fs;
      w = sb.clamp(sb.img_w, 1, MaxWidth);
      h = sb.clamp(sb.img_h, 1, MaxHeight);
      for (int unsigned p = 0; p < w * h; p++) begin
         fs = (p == 0) && (need_frame_start || $urandom_range(1));
         if (noisy && $urandom_range(99) == 0) fs = 1'b1;
         send_pixel(pick_pixel(), fs);
         need_frame_start = 1'b0;
         if (noisy && $urandom_range(199) == 0) begin
            need_frame_start = 1'b1;
            break;
         end
      end
   endtask

   task automatic random_phase(int unsigned target);
      int unsigned wr, wc, n;
      logic [24:0] msk;
      while (pixels_sent < target) begin
         wr = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5, 1);
         wc = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5, 1);
         case ($urandom_range(4))
            0: msk = 25'h1FFFFFF;
            1: msk = 25'($urandom) & 25'($urandom);
            default: msk = 25'($urandom);
         endcase
         n = $countones(msk);
         configure($urandom_range(9) == 0 ? $urandom_range(12) : $urandom_range(10, 1),
                   $urandom_range(9) == 0 ? $urandom_range(12) : $urandom_range(8, 1),
                   wr, wc, msk,
                   $urandom_range(4) == 0 ? $urandom_range(31)
                                          : $urandom_range(n > 25 ? 25 : (n < 1 ? 1 : n), 1));
         repeat ($urandom_range(3, 1)) send_frame($urandom_range(3) == 0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 17;
      recv_idle = 60;
      // median 3x3, extreme pixels
      configure(4, 3, 3, 3, 25'h1FF, 5);
      send_pixel(8'd0, 1'b1);
      for (int p = 1; p < 12; p++) send_pixel((p % 2) ? 8'd255 : 8'd0, 1'b0);
      // empty mask, then rank beyond count, then rank zero
      configure(3, 3, 3, 3, 25'd0, 1);
      send_frame(0);
      configure(3, 3, 3, 3, 25'h1FF, 10);
      send_frame(0);
      configure(3, 3, 3, 3, 25'h1FF, 0);
      send_frame(0);
      // full 5x5 window, top rank; 1x1 pass-through
      configure(5, 5, 5, 5, 25'h1FFFFFF, 25);
      send_frame(0);
      configure(2, 2, 1, 1, 25'h1, 1);
      send_frame(0);
      send_frame(0);
      // image smaller than window: no output
      configure(2, 2, 3, 3, 25'h1FF, 1);
      send_frame(0);
      // clamped registers: zero and over-range sizes
      configure(0, 0, 0, 7, 25'h1F, 1);
      send_frame(0);

      random_phase(450);
      send_idle = 60;
      recv_idle = 17;
      random_phase(850);
      send_idle = 0;
      recv_idle = 0;
      random_phase(1250);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (sb.expected_outputs.size() == 0);
      repeat (40) @(posedge clock);
      if (sb.failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

[masked_rank_window_filter.f]
+incdir+rtl/core
rtl/core/mrwf_pkg.sv
rtl/core/mrwf_rank_cell.sv
rtl/core/mrwf_rank_chain.sv
rtl/core/masked_rank_window_filter.sv
rtl/core/mrwf_port_checker.sv
dv/masked_rank_window_filter_tb.sv
